### sv/obfd_pkg.sv
// Shared types and constants for the breadth-first octree decoder.
// Used by obfd_ctrl, obfd_datapath and the top level; no dependencies.
package obfd_pkg;

    localparam int QUEUE_DEPTH = 4096;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int COORD_W     = 32;
    localparam int SIDE_W      = 31;
    localparam int SHIFT_MAX   = 31;

    typedef enum logic [1:0] {
        FUNC_START     = 2'd0,
        FUNC_OCCUPANCY = 2'd1,
        FUNC_LEAF      = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_ROOT_X    = 2'd0,
        REG_ROOT_Y    = 2'd1,
        REG_ROOT_Z    = 2'd2,
        REG_ROOT_SIDE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_LEAF,
        S_EMPTY,
        S_OVF
    } state_t;

    typedef struct packed {
        logic    start;
        logic    pop;
        logic    child_step;
        logic    level_step;
        logic    load_out;
        status_t out_status;
    } obfd_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic last_step;
        logic overflow;
        logic out_free;
    } obfd_stat_t;

    function automatic logic [QAW-1:0] ring_next(input logic [QAW-1:0] i);
        return (i == QAW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

### sv/obfd_ctrl.sv
// Sequencer for the octree decoder: takes requests and steps the datapath.
// Depends on obfd_pkg for state, command and status types.
module obfd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             func,
    input  obfd_pkg::obfd_stat_t   stat,
    output obfd_pkg::obfd_cmd_t    cmd
);
    import obfd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.out_status = STATUS_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_START:
                        begin
                            cmd.start = 1'b1;
                        end
                        FUNC_OCCUPANCY:
                        begin
                            if (stat.queue_empty)
                            begin
                                state_next = S_EMPTY;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = S_EXPAND;
                            end
                        end
                        FUNC_LEAF:
                        begin
                            if (stat.queue_empty)
                            begin
                                state_next = S_EMPTY;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = S_LEAF;
                            end
                        end
                        default:
                        begin
                            // drop the unused code
                        end
                    endcase
                end
            end
            S_EXPAND:
            begin
                cmd.child_step = 1'b1;
                if (stat.last_step)
                begin
                    cmd.level_step = 1'b1;
                    state_next     = stat.overflow ? S_OVF : S_IDLE;
                end
            end
            S_LEAF:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                cmd.out_status = STATUS_EMPTY;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_OVF:
            begin
                cmd.out_status = STATUS_OVERFLOW;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/obfd_datapath.sv
// Datapath of the octree decoder: root registers, center queue memory,
// level counters, child generation and the output register. Uses obfd_pkg.
module obfd_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic [7:0]                  payload,
    input  obfd_pkg::obfd_cmd_t         cmd,
    output obfd_pkg::obfd_stat_t        stat,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic signed [31:0]          center_x,
    output logic signed [31:0]          center_y,
    output logic signed [31:0]          center_z,
    output logic [7:0]                  repeat_count,
    output logic [1:0]                  status
);
    import obfd_pkg::*;

    logic [COORD_W-1:0]   root_x_reg;
    logic [COORD_W-1:0]   root_y_reg;
    logic [COORD_W-1:0]   root_z_reg;
    logic [SIDE_W-1:0]    root_side_reg;

    logic [3*COORD_W-1:0] queue_mem [QUEUE_DEPTH];
    logic [3*COORD_W-1:0] rd_data_reg;

    logic [QAW-1:0]       head_reg, head_next;
    logic [QAW-1:0]       tail_reg, tail_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    level_left_reg, level_left_next;
    logic [FILL_W-1:0]    nls_reg, nls_next;
    logic [4:0]           shift_reg, shift_next;

    logic [SIDE_W-1:0]    margin_reg;
    logic [7:0]           payload_reg;
    logic [2:0]           step_reg;
    logic                 ovf_reg;

    logic                 out_valid_reg;
    logic [COORD_W-1:0]   out_x_reg;
    logic [COORD_W-1:0]   out_y_reg;
    logic [COORD_W-1:0]   out_z_reg;
    logic [7:0]           out_count_reg;
    logic [1:0]           out_status_reg;

    logic                 queue_full;
    logic                 cur_bit;
    logic                 do_push;
    logic                 step_ovf;
    logic [COORD_W-1:0]   margin_ext;
    logic [COORD_W-1:0]   par_x, par_y, par_z;
    logic [COORD_W-1:0]   child_x, child_y, child_z;
    logic                 wr_en;
    logic [QAW-1:0]       wr_addr;
    logic [3*COORD_W-1:0] wr_data;
    logic [FILL_W-1:0]    nls_inc;
    logic [FILL_W-1:0]    left_dec;
    logic [5:0]           shift_amt;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_x_reg    <= '0;
            root_y_reg    <= '0;
            root_z_reg    <= '0;
            root_side_reg <= SIDE_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROOT_X:    root_x_reg    <= cfg_data;
                REG_ROOT_Y:    root_y_reg    <= cfg_data;
                REG_ROOT_Z:    root_z_reg    <= cfg_data;
                REG_ROOT_SIDE: root_side_reg <= cfg_data[SIDE_W-1:0];
                default:       root_x_reg    <= root_x_reg;
            endcase
        end
    end

    assign queue_full = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign cur_bit    = payload_reg[step_reg];
    assign do_push    = cmd.child_step && cur_bit && !queue_full;
    assign step_ovf   = cmd.child_step && cur_bit && queue_full;

    assign margin_ext = {1'b0, margin_reg};
    assign par_x      = rd_data_reg[3*COORD_W-1:2*COORD_W];
    assign par_y      = rd_data_reg[2*COORD_W-1:COORD_W];
    assign par_z      = rd_data_reg[COORD_W-1:0];
    assign child_x    = step_reg[2] ? par_x + margin_ext : par_x - margin_ext;
    assign child_y    = step_reg[1] ? par_y + margin_ext : par_y - margin_ext;
    assign child_z    = step_reg[0] ? par_z + margin_ext : par_z - margin_ext;

    assign wr_en   = cmd.start || do_push;
    assign wr_addr = cmd.start ? '0 : tail_reg;
    assign wr_data = cmd.start ? {root_x_reg, root_y_reg, root_z_reg}
                               : {child_x, child_y, child_z};

    // queue memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_addr] <= wr_data;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    assign shift_amt = {1'b0, shift_reg} + 6'd2;
    assign nls_inc   = (do_push && nls_reg < FILL_W'(QUEUE_DEPTH)) ? nls_reg + 1'b1 : nls_reg;
    assign left_dec  = (level_left_reg == '0) ? '0 : level_left_reg - 1'b1;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        level_left_next = level_left_reg;
        nls_next        = nls_inc;
        shift_next      = shift_reg;
        if (cmd.start)
        begin
            head_next       = '0;
            tail_next       = ring_next('0);
            fill_next       = FILL_W'(1);
            level_left_next = FILL_W'(1);
            nls_next        = '0;
            shift_next      = '0;
        end
        else
        begin
            if (cmd.pop)
            begin
                head_next = ring_next(head_reg);
                fill_next = fill_reg - 1'b1;
            end
            else if (do_push)
            begin
                tail_next = ring_next(tail_reg);
                fill_next = fill_reg + 1'b1;
            end
            if (cmd.level_step)
            begin
                if (left_dec == '0)
                begin
                    // level done: children become the next level
                    level_left_next = nls_inc;
                    nls_next        = '0;
                    shift_next      = (shift_reg == 5'(SHIFT_MAX)) ? shift_reg
                                                                  : shift_reg + 1'b1;
                end
                else
                begin
                    level_left_next = left_dec;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            level_left_reg <= '0;
            nls_reg        <= '0;
            shift_reg      <= '0;
            step_reg       <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            level_left_reg <= level_left_next;
            nls_reg        <= nls_next;
            shift_reg      <= shift_next;
            if (cmd.pop)
            begin
                step_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (cmd.child_step)
            begin
                step_reg <= step_reg + 1'b1;
                ovf_reg  <= ovf_reg || step_ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            payload_reg <= payload;
            margin_reg  <= root_side_reg >> shift_amt;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_status == STATUS_OK)
            begin
                out_x_reg     <= par_x;
                out_y_reg     <= par_y;
                out_z_reg     <= par_z;
                out_count_reg <= payload_reg;
            end
            else
            begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_z_reg     <= '0;
                out_count_reg <= '0;
            end
        end
    end

    assign stat.queue_empty = (fill_reg == '0);
    assign stat.last_step   = (step_reg == 3'd7);
    assign stat.overflow    = ovf_reg || step_ovf;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign center_x     = out_x_reg;
    assign center_y     = out_y_reg;
    assign center_z     = out_z_reg;
    assign repeat_count = out_count_reg;
    assign status       = out_status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> fill_reg != '0)
        else $error("pop from empty queue");

    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("fill not decremented by pop");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a pending result");

endmodule

### sv/octree_breadth_first_decode_core.sv
// Breadth-first octree decoder. A start request loads the root center into a
// 4096-entry center queue (one write port and one registered read port); an
// occupancy request pops a parent and then steps through the mask bits, eight
// in all, pushing a child for each set bit while the queue has room, and
// reports an overflow when a set bit finds the queue full. A leaf-count
// request pops, then the queue read data goes to the output register; a
// request that finds the queue empty reports an empty status. One request
// is worked at a time; a result waits in the output register while the
// next request is taken. The user must write the root registers through
// cfg_we/cfg_index/cfg_data only while idle; the block does not check it.
module octree_breadth_first_decode_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [7:0]           payload,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   center_x,
    output logic signed [31:0]   center_y,
    output logic signed [31:0]   center_z,
    output logic [7:0]           repeat_count,
    output logic [1:0]           status
);
    import obfd_pkg::*;

    obfd_cmd_t  cmd;
    obfd_stat_t stat;

    obfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    obfd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .payload      (payload),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .repeat_count (repeat_count),
        .status       (status)
    );

endmodule
